FILE: design/brqo_pkg.sv
// shared types and constants of the bounded record queue
`timescale 1ns / 1ps

package brqo_pkg;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int LIMIT_W    = 13;
    localparam int SAMPLE_W   = 16;
    localparam int WORD_W     = 32;
    localparam int DEPTH_W    = 13;

    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_ENABLED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_PAYLOAD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SAMPLE_LEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OVERFLOW_MODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT    = 3'd4;

    localparam logic [1:0] MODE_DROP_OLDEST = 2'd0;
    localparam logic [1:0] MODE_DROP_NEWEST = 2'd1;
    localparam logic [1:0] MODE_META_ONLY   = 2'd2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [LIMIT_W-1:0]  DEFAULT_LIMIT      = 13'd4096;
    localparam logic [SAMPLE_W-1:0] DEFAULT_MAX_SAMPLE = 16'd256;

    typedef struct packed {
        logic [WORD_W-1:0]   meta;
        logic [WORD_W-1:0]   size;
        logic [SAMPLE_W-1:0] sample;
    } rec_t;

endpackage

FILE: design/brqo_ring.sv
// record ring storage: one write port, one registered read port
`timescale 1ns / 1ps

module brqo_ring
    import brqo_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  rec_t          wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output rec_t          rd_data
);

    rec_t mem [DEPTH];
    rec_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/bounded_record_queue_overflow.sv
// bounded record queue with overflow drop policy, top level
//
//  channel   ports                                           handshake
//  request   start, busy, op, rec_meta, rec_payload_len      start & !busy
//  result    done, ok, out_meta, out_payload_size,           done, one cycle
//            out_sample_len, depth, *_total
//  config    cfg_wr_en, cfg_index, cfg_data                  cfg_wr_en
//
// one request per cycle; busy stays low, the ring has separate read and write ports
// the result of a request shows in the cycle after it is taken, for that cycle only
// a pop reads the head entry from the ring memory, whose registered read port sets that delay
// reset clears pointers and counters and loads the register defaults; ring contents
// stay unknown until written
// the receiver cannot stall, so nothing is held back on the result side
`timescale 1ns / 1ps

module bounded_record_queue_overflow
    import brqo_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  op,
    input  logic [WORD_W-1:0]     rec_meta,
    input  logic [WORD_W-1:0]     rec_payload_len,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  done,
    output logic                  ok,
    output logic [WORD_W-1:0]     out_meta,
    output logic [WORD_W-1:0]     out_payload_size,
    output logic [SAMPLE_W-1:0]   out_sample_len,
    output logic [DEPTH_W-1:0]    depth,
    output logic [WORD_W-1:0]     pushed_total,
    output logic [WORD_W-1:0]     popped_total,
    output logic [WORD_W-1:0]     lost_total
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(QUEUE_DEPTH);
    localparam logic [CMP_W-1:0] CMP_DEPTH = CMP_W'(QUEUE_DEPTH);

    // configuration
    logic                enabled_reg;
    logic                keep_reg;
    logic [SAMPLE_W-1:0] max_sample_reg;
    logic [1:0]          mode_reg;
    logic [LIMIT_W-1:0]  limit_reg;

    // queue state
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [WORD_W-1:0] push_cnt_reg, push_cnt_next;
    logic [WORD_W-1:0] pop_cnt_reg, pop_cnt_next;
    logic [WORD_W-1:0] loss_cnt_reg, loss_cnt_next;

    // result flags
    logic done_reg;
    logic ok_reg, ok_next;
    logic pop_hit_reg, pop_hit_next;

    logic              accept;
    logic [LIMIT_W-1:0] limit_raw;
    logic [CMP_W-1:0]  limit_eff;
    logic              full;
    logic [PTR_W-1:0]  head_inc;
    logic [SUM_W-1:0]  tail_sum;
    logic [PTR_W-1:0]  tail_ptr;
    logic [SAMPLE_W-1:0] sample_capped;
    logic [SAMPLE_W-1:0] sample_val;
    logic              wr_en;
    logic              rd_en;
    rec_t              wr_rec;
    rec_t              rd_rec;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg    <= 1'b1;
            keep_reg       <= 1'b1;
            max_sample_reg <= DEFAULT_MAX_SAMPLE;
            mode_reg       <= MODE_DROP_OLDEST;
            limit_reg      <= DEFAULT_LIMIT;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_QUEUE_ENABLED:  enabled_reg    <= cfg_data[0];
                REG_KEEP_PAYLOAD:   keep_reg       <= cfg_data[0];
                REG_MAX_SAMPLE_LEN: max_sample_reg <= cfg_data;
                REG_OVERFLOW_MODE:  mode_reg       <= cfg_data[1:0];
                REG_QUEUE_LIMIT:    limit_reg      <= cfg_data[LIMIT_W-1:0];
                default:            ;
            endcase
        end
    end

    // effective limit: zero means the default, capped at the ring size
    assign limit_raw = (limit_reg == '0) ? DEFAULT_LIMIT : limit_reg;
    assign limit_eff = (CMP_W'(limit_raw) > CMP_DEPTH) ? CMP_DEPTH : CMP_W'(limit_raw);
    assign full      = CMP_W'(fill_reg) >= limit_eff;

    assign head_inc = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;

    // tail is head plus fill whether or not the head is evicted first
    assign tail_sum = SUM_W'(head_reg) + SUM_W'(fill_reg);
    assign tail_ptr = (tail_sum >= SUM_DEPTH) ? PTR_W'(tail_sum - SUM_DEPTH)
                                              : PTR_W'(tail_sum);

    assign sample_capped = (rec_payload_len < WORD_W'(max_sample_reg))
                           ? rec_payload_len[SAMPLE_W-1:0] : max_sample_reg;

    always_comb
    begin
        head_next     = head_reg;
        fill_next     = fill_reg;
        push_cnt_next = push_cnt_reg;
        pop_cnt_next  = pop_cnt_reg;
        loss_cnt_next = loss_cnt_reg;
        ok_next       = 1'b0;
        pop_hit_next  = 1'b0;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        sample_val    = keep_reg ? sample_capped : '0;

        if (accept)
        begin
            if (op == OP_POP)
            begin
                if (fill_reg != '0)
                begin
                    rd_en        = 1'b1;
                    head_next    = head_inc;
                    fill_next    = fill_reg - 1'b1;
                    pop_cnt_next = pop_cnt_reg + 1'b1;
                    ok_next      = 1'b1;
                    pop_hit_next = 1'b1;
                end
            end
            else if (enabled_reg)
            begin
                if (full && mode_reg == MODE_DROP_NEWEST)
                begin
                    loss_cnt_next = loss_cnt_reg + 1'b1;
                end
                else
                begin
                    if (full)
                    begin
                        case (mode_reg)
                            MODE_META_ONLY: sample_val = '0;
                            default:        ;
                        endcase
                        head_next     = head_inc;
                        loss_cnt_next = loss_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    wr_en         = 1'b1;
                    push_cnt_next = push_cnt_reg + 1'b1;
                    ok_next       = 1'b1;
                end
            end
        end
    end

    assign wr_rec.meta   = rec_meta;
    assign wr_rec.size   = rec_payload_len;
    assign wr_rec.sample = sample_val;

    brqo_ring #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (PTR_W)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_ptr),
        .wr_data (wr_rec),
        .rd_en   (rd_en),
        .rd_addr (head_reg),
        .rd_data (rd_rec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            fill_reg     <= '0;
            push_cnt_reg <= '0;
            pop_cnt_reg  <= '0;
            loss_cnt_reg <= '0;
            done_reg     <= 1'b0;
            ok_reg       <= 1'b0;
            pop_hit_reg  <= 1'b0;
        end
        else
        begin
            head_reg     <= head_next;
            fill_reg     <= fill_next;
            push_cnt_reg <= push_cnt_next;
            pop_cnt_reg  <= pop_cnt_next;
            loss_cnt_reg <= loss_cnt_next;
            done_reg     <= accept;
            ok_reg       <= ok_next;
            pop_hit_reg  <= pop_hit_next;
        end
    end

    assign done             = done_reg;
    assign ok               = ok_reg;
    assign out_meta         = pop_hit_reg ? rd_rec.meta   : '0;
    assign out_payload_size = pop_hit_reg ? rd_rec.size   : '0;
    assign out_sample_len   = pop_hit_reg ? rd_rec.sample : '0;
    assign depth            = DEPTH_W'(fill_reg);
    assign pushed_total     = push_cnt_reg;
    assign popped_total     = pop_cnt_reg;
    assign lost_total       = loss_cnt_reg;

endmodule
